@@ hdl/dda_pkg.sv @@
package dda_pkg;

	localparam int TILE_SIZE = 64;
	localparam int COORD_W = 10;
	localparam int PIX_W = 6;
	localparam int COORD_FRAC_BITS = 4;
	localparam int SLOPE_FRAC_BITS = 16;
	localparam int FRAC_GAP = SLOPE_FRAC_BITS - COORD_FRAC_BITS;
	localparam int QUO_W = SLOPE_FRAC_BITS + 1;
	localparam int SLOPE_W = QUO_W + 1;
	localparam int DIFF_W = COORD_W + 1;
	localparam int PROD_W = SLOPE_W + DIFF_W;
	localparam int ACC_W = 26;
	localparam int CNT_W = 5;

	typedef struct packed {
		logic [COORD_W-1:0] start_x;
		logic [COORD_W-1:0] start_y;
		logic [COORD_W-1:0] end_x;
		logic [COORD_W-1:0] end_y;
	} seg_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_x;
		logic [PIX_W-1:0] pixel_y;
		logic             last_pixel;
	} pix_t;

	typedef struct packed {
		logic load;
		logic div_step;
		logic mul;
		logic init;
		logic step;
	} cmd_t;

	typedef struct packed {
		logic vert;
		logic out_free;
		logic last;
	} status_t;

	function automatic logic [PIX_W-1:0] round_coord(input logic [COORD_W-1:0] v);
		logic [COORD_W:0] t;
		t = {1'b0, v} + (COORD_W+1)'(1 << (COORD_FRAC_BITS - 1));
		if (t[COORD_W:COORD_FRAC_BITS] > (COORD_W+1-COORD_FRAC_BITS)'(TILE_SIZE - 1)) begin
			return PIX_W'(TILE_SIZE - 1);
		end
		return t[COORD_FRAC_BITS+PIX_W-1:COORD_FRAC_BITS];
	endfunction

endpackage

@@ hdl/dda_ctrl.sv @@
module dda_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              seg_valid,
	output logic              seg_ready,
	input  dda_pkg::status_t  status,
	output dda_pkg::cmd_t     cmd
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_DIV  = 5'b00010,
		ST_MUL  = 5'b00100,
		ST_INIT = 5'b01000,
		ST_WALK = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic [dda_pkg::CNT_W-1:0] cnt_q;

	assign seg_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (seg_valid) begin
					cmd.load = 1'b1;
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (status.vert) begin
					state_d = ST_MUL;
				end else begin
					cmd.div_step = 1'b1;
					if (cnt_q == '0) begin
						state_d = ST_MUL;
					end
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_INIT;
			end
			ST_INIT: begin
				cmd.init = 1'b1;
				state_d = ST_WALK;
			end
			ST_WALK: begin
				if (status.out_free) begin
					cmd.step = 1'b1;
					if (status.last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				cnt_q <= dda_pkg::CNT_W'(dda_pkg::QUO_W - 1);
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_step_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> status.out_free) else $error("step without free output");
	a_busy_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		(seg_valid && seg_ready) |=> !seg_ready) else $error("ready after load");
	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL && $past(state_q) == ST_DIV && !status.vert) |->
		$past(cnt_q) == '0) else $error("divide ended early");

endmodule

@@ hdl/dda_datapath.sv @@
module dda_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  dda_pkg::seg_t     seg,
	input  dda_pkg::cmd_t     cmd,
	output dda_pkg::status_t  status,
	output logic              pix_valid,
	input  logic              pix_ready,
	output dda_pkg::pix_t     pix
);

	localparam int CW = dda_pkg::COORD_W;
	localparam int PW = dda_pkg::PIX_W;

	logic signed [CW:0] dx, dy;
	logic [CW-1:0] adx, ady, amin_d, amaj_d, lo_d, hi_d, mst_d;
	logic ymaj_d, vert_d, neg_d, first_d;

	logic [CW-1:0] amaj_q, maj_lo_q, min_start_q;
	logic [CW:0] rem_q, rem_sub;
	logic [dda_pkg::QUO_W-1:0] quo_q;
	logic neg_q, ymaj_q, vert_q;
	logic [PW-1:0] pos_q, end_q;
	logic signed [dda_pkg::PROD_W-1:0] prod_q, prod_r;
	logic signed [dda_pkg::ACC_W-1:0] acc_q, acc_r;
	logic signed [dda_pkg::SLOPE_W-1:0] slope;
	logic signed [dda_pkg::DIFF_W-1:0] diff;
	logic signed [dda_pkg::PROD_W-dda_pkg::COORD_FRAC_BITS-1:0] corr;
	logic signed [dda_pkg::ACC_W-dda_pkg::SLOPE_FRAC_BITS-1:0] mp;
	logic [PW-1:0] mp_sat;
	logic out_valid_q;
	dda_pkg::pix_t pix_q;

	always_comb begin
		dx = $signed({1'b0, seg.end_x}) - $signed({1'b0, seg.start_x});
		dy = $signed({1'b0, seg.end_y}) - $signed({1'b0, seg.start_y});
		adx = dx[CW] ? CW'(-dx) : dx[CW-1:0];
		ady = dy[CW] ? CW'(-dy) : dy[CW-1:0];
		vert_d = (dx == '0);
		ymaj_d = vert_d || (ady > adx);
		if (ymaj_d) begin
			amaj_d = ady;
			amin_d = adx;
			neg_d = dx[CW] != dy[CW];
			first_d = seg.start_y < seg.end_y;
			lo_d = first_d ? seg.start_y : seg.end_y;
			hi_d = first_d ? seg.end_y : seg.start_y;
			mst_d = first_d ? seg.start_x : seg.end_x;
		end else begin
			amaj_d = adx;
			amin_d = ady;
			neg_d = dx[CW] != dy[CW];
			first_d = seg.start_x < seg.end_x;
			lo_d = first_d ? seg.start_x : seg.end_x;
			hi_d = first_d ? seg.end_x : seg.start_x;
			mst_d = first_d ? seg.start_y : seg.end_y;
		end
		if (vert_d) begin
			mst_d = seg.start_x;
		end
	end

	assign rem_sub = rem_q - {1'b0, amaj_q};
	assign slope = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
	assign diff = $signed({1'b0, pos_q, dda_pkg::COORD_FRAC_BITS'(0)}) -
		$signed({1'b0, maj_lo_q});
	assign prod_r = prod_q + dda_pkg::PROD_W'(1 << (dda_pkg::COORD_FRAC_BITS - 1));
	assign corr = prod_r[dda_pkg::PROD_W-1:dda_pkg::COORD_FRAC_BITS];
	assign acc_r = acc_q + dda_pkg::ACC_W'(1 << (dda_pkg::SLOPE_FRAC_BITS - 1));
	assign mp = acc_r[dda_pkg::ACC_W-1:dda_pkg::SLOPE_FRAC_BITS];

	always_comb begin
		if (mp < 0) begin
			mp_sat = '0;
		end else if (mp > (dda_pkg::TILE_SIZE - 1)) begin
			mp_sat = PW'(dda_pkg::TILE_SIZE - 1);
		end else begin
			mp_sat = mp[PW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			amaj_q <= amaj_d;
			rem_q <= {1'b0, amin_d};
			quo_q <= '0;
			neg_q <= neg_d;
			ymaj_q <= ymaj_d;
			vert_q <= vert_d;
			maj_lo_q <= lo_d;
			min_start_q <= mst_d;
			pos_q <= dda_pkg::round_coord(lo_d);
			end_q <= dda_pkg::round_coord(hi_d);
		end else if (cmd.div_step) begin
			if (rem_q >= {1'b0, amaj_q}) begin
				quo_q <= {quo_q[dda_pkg::QUO_W-2:0], 1'b1};
				rem_q <= {rem_sub[CW-1:0], 1'b0};
			end else begin
				quo_q <= {quo_q[dda_pkg::QUO_W-2:0], 1'b0};
				rem_q <= {rem_q[CW-1:0], 1'b0};
			end
		end else if (cmd.step) begin
			pos_q <= pos_q + 1'b1;
		end
		if (cmd.mul) begin
			prod_q <= slope * diff;
		end
		if (cmd.init) begin
			acc_q <= $signed({(dda_pkg::ACC_W-CW-dda_pkg::FRAC_GAP)'(0), min_start_q,
				dda_pkg::FRAC_GAP'(0)}) + dda_pkg::ACC_W'(corr);
		end else if (cmd.step) begin
			acc_q <= acc_q + dda_pkg::ACC_W'(slope);
		end
		if (cmd.step) begin
			pix_q.pixel_x <= ymaj_q ? mp_sat : pos_q;
			pix_q.pixel_y <= ymaj_q ? pos_q : mp_sat;
			pix_q.last_pixel <= (pos_q == end_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.step) begin
			out_valid_q <= 1'b1;
		end else if (pix_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign status.vert = vert_q;
	assign status.out_free = !out_valid_q || pix_ready;
	assign status.last = (pos_q == end_q);
	assign pix_valid = out_valid_q;
	assign pix = pix_q;

endmodule

@@ hdl/dda_line_rasterizer.sv @@
// Channel   Direction  Handshake             Payload
// seg       in         seg_valid/seg_ready   dda_pkg::seg_t, two endpoints
// pix       out        pix_valid/pix_ready   dda_pkg::pix_t, one pixel
//
// A segment passes through a load, a serial slope divide (idle for a vertical segment),
// a multiply and a setup, then a walk of one pixel per cycle while pix is not stalled,
// up to 64 pixels. The serial slope divider and the single pixel walk set its time.
// A new segment is taken once the last pixel sits in the output register.
// A stall on pix holds the walk; reset clears the controller and the output valid.
module dda_line_rasterizer (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           seg_valid,
	output logic           seg_ready,
	input  dda_pkg::seg_t  seg,
	output logic           pix_valid,
	input  logic           pix_ready,
	output dda_pkg::pix_t  pix
);

	dda_pkg::cmd_t cmd;
	dda_pkg::status_t status;

	dda_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.seg_valid (seg_valid),
		.seg_ready (seg_ready),
		.status    (status),
		.cmd       (cmd)
	);

	dda_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.seg       (seg),
		.cmd       (cmd),
		.status    (status),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix       (pix)
	);

endmodule
